/* design/tofd_pkg.sv */
// ----------------------------------------------------------------------------
// tofd_pkg
// Shared constants and types for the four-phase ToF depth pipeline.
// ----------------------------------------------------------------------------
package tofd_pkg;

    // Angle arithmetic, Q24 radians
    localparam int unsigned FRAC_BITS = 24;
    localparam logic [19:0] COEF_C3_MAG = 20'd780081;   // magnitude of negative C3
    localparam logic [21:0] COEF_C2     = 22'd2672849;
    localparam logic [22:0] COEF_C1     = 23'd5496598;
    localparam logic signed [27:0] Q24_HALFPI = 28'sd26353590;
    localparam logic signed [27:0] Q24_PI     = 28'sd52707180;
    localparam logic signed [27:0] Q24_TAU_S  = 28'sd105414357;
    localparam logic [26:0] Q24_TAU    = 27'd105414357;

    // Depth scaling: d = floor(r * scale / TAU), via reciprocal plus one fix-up
    localparam int unsigned RECIP_SHIFT = 28;
    localparam logic [17:0] RECIP_WIDE   = 18'd166883; // floor(65535*2^28/TAU)
    localparam logic [17:0] RECIP_NARROW = 18'd10427;  // floor(4095*2^28/TAU)
    localparam logic [15:0] SCALE_WIDE   = 16'd65535;
    localparam logic [15:0] SCALE_NARROW = 16'd4095;

    // Register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_NARROW    = 1'b1;

    // Pipeline geometry
    localparam int unsigned LOOP_STAGES = 12;  // 2 quotient bits per stage
    localparam int unsigned SQRT_STAGES = 8;   // 2 root bits per stage
    localparam int unsigned DEPTH       = 23;  // total register stages

    // Per-item flags carried down the pipe
    typedef struct packed {
        logic        keep;   // amplitude above threshold
        logic        xneg;
        logic        yneg;
        logic        swp;    // |y| > |x|
        logic [14:0] amp;
    } side_t;

endpackage

/* design/four_phase_tof_depth.sv */
// ----------------------------------------------------------------------------
// four_phase_tof_depth
// Four-phase CW time-of-flight demodulation: phase angle to depth code,
// amplitude and low-amplitude masking for one pixel per clock.
// ----------------------------------------------------------------------------
// Pipeline: 23 register stages from input transfer to result valid.
// Throughput: one pixel per clock; the whole pipe advances together and
// holds only while the output register is full and stalled.
// The quotient (25 bits) takes one bit in stage 2, then two bits per stage across
// 12 stages; the square root (16 bits) takes two bits per stage in the first 8 of them.
// The arctangent polynomial uses one multiply per stage.
// Reset clears all valid bits and sets threshold 0 and the 16-bit depth scale.
// ----------------------------------------------------------------------------
module four_phase_tof_depth
    import tofd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // sample channel
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [11:0] sample_a,
    input  logic [11:0] sample_b,
    input  logic [11:0] sample_c,
    input  logic [11:0] sample_d,
    // depth channel
    output logic        depth_valid,
    input  logic        depth_stall,
    output logic [15:0] depth_code,
    output logic [15:0] amplitude,
    output logic        masked
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] thr_reg;
    logic        narrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            narrow_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg    <= cfg_wdata;
                CFG_NARROW:    narrow_reg <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves at once unless the output register
    // holds a result that is stalled.
    // ------------------------------------------------------------------
    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv          = !(vld_reg[DEPTH-1] && depth_stall);
    assign sample_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], sample_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: sign-extend samples, difference vector, octant flags, squares.
    // The x16 sample gain cancels in the angle, so x and y stay unscaled here.
    // ------------------------------------------------------------------
    logic signed [11:0] x_c, y_c;
    logic [10:0]        ax_c, ay_c;
    logic [11:0]        xabs_c, yabs_c;

    assign x_c    = {sample_d[10], sample_d[10:0]} - {sample_b[10], sample_b[10:0]};
    assign y_c    = {sample_c[10], sample_c[10:0]} - {sample_a[10], sample_a[10:0]};
    assign xabs_c = x_c[11] ? 12'(-x_c) : 12'(x_c);
    assign yabs_c = y_c[11] ? 12'(-y_c) : 12'(y_c);
    assign ax_c   = xabs_c[10:0];
    assign ay_c   = yabs_c[10:0];

    logic        s1_xneg_reg, s1_yneg_reg, s1_swp_reg;
    logic [10:0] s1_hi_reg, s1_lo_reg;
    logic [21:0] s1_sqx_reg, s1_sqy_reg;

    // ------------------------------------------------------------------
    // Stage 2: squared length, threshold square, first quotient bit.
    // Index 0 of the loop arrays is the stage 2 output.
    // ------------------------------------------------------------------
    logic [22:0] m_c;
    logic [30:0] l2_c;
    logic        q0_c;

    assign m_c  = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
    assign l2_c = {m_c, 8'd0};
    assign q0_c = (s1_lo_reg >= s1_hi_reg);

    logic [31:0] tsq_reg;
    logic [30:0] l2_reg;

    logic [10:0] div_rem_reg  [0:LOOP_STAGES];
    logic [24:0] div_q_reg    [0:LOOP_STAGES];
    logic [10:0] div_hi_reg   [0:LOOP_STAGES];
    logic [17:0] sq_rem_reg   [0:LOOP_STAGES];
    logic [15:0] sq_root_reg  [0:LOOP_STAGES];
    logic [31:0] sq_v_reg     [0:LOOP_STAGES];
    side_t       side_reg     [0:LOOP_STAGES];

    // threshold test l2 > 4*t^2 lands in the first loop stage
    side_t       side1_c;

    always_comb
    begin
        side1_c      = side_reg[0];
        side1_c.keep = ({3'b000, l2_reg} > {tsq_reg, 2'b00});
    end

    // ------------------------------------------------------------------
    // Loop stages: restoring divide lo*2^24/hi and digit-by-digit sqrt
    // ------------------------------------------------------------------
    function automatic logic [35:0] div_step(input logic [10:0] rem, input logic [24:0] q,
                                             input logic [10:0] hi);
        logic [11:0] t;
        logic [10:0] rn;
        logic [24:0] qn;
        t = {rem, 1'b0};
        if (t >= {1'b0, hi})
        begin
            rn = 11'(t - {1'b0, hi});
            qn = {q[23:0], 1'b1};
        end
        else
        begin
            rn = t[10:0];
            qn = {q[23:0], 1'b0};
        end
        return {rn, qn};
    endfunction

    function automatic logic [65:0] sqrt_step(input logic [17:0] rem,
                                              input logic [15:0] root,
                                              input logic [31:0] v);
        logic [19:0] sh;
        logic [19:0] trial;
        logic [17:0] rn;
        logic [15:0] qn;
        sh    = {rem, v[31:30]};
        trial = {2'b00, root, 2'b01};
        if (sh >= trial)
        begin
            rn = 18'(sh - trial);
            qn = {root[14:0], 1'b1};
        end
        else
        begin
            rn = sh[17:0];
            qn = {root[14:0], 1'b0};
        end
        return {rn, qn, v[29:0], 2'b00};
    endfunction

    logic [10:0] div_rem_next  [0:LOOP_STAGES-1];
    logic [24:0] div_q_next    [0:LOOP_STAGES-1];
    logic [17:0] sq_rem_next   [0:LOOP_STAGES-1];
    logic [15:0] sq_root_next  [0:LOOP_STAGES-1];
    logic [31:0] sq_v_next     [0:LOOP_STAGES-1];

    always_comb
    begin
        logic [35:0] d1, d2;
        logic [65:0] r1, r2;
        for (int k = 0; k < LOOP_STAGES; k++)
        begin
            d1 = div_step(div_rem_reg[k], div_q_reg[k], div_hi_reg[k]);
            d2 = div_step(d1[35:25], d1[24:0], div_hi_reg[k]);
            div_rem_next[k] = d2[35:25];
            div_q_next[k]   = d2[24:0];
            if (k < SQRT_STAGES)
            begin
                r1 = sqrt_step(sq_rem_reg[k], sq_root_reg[k], sq_v_reg[k]);
                r2 = sqrt_step(r1[65:48], r1[47:32], r1[31:0]);
                sq_rem_next[k]  = r2[65:48];
                sq_root_next[k] = r2[47:32];
                sq_v_next[k]    = r2[31:0];
            end
            else
            begin
                sq_rem_next[k]  = sq_rem_reg[k];
                sq_root_next[k] = sq_root_reg[k];
                sq_v_next[k]    = sq_v_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Arctangent polynomial, magnitudes only (all truncations toward zero)
    // ------------------------------------------------------------------
    logic [24:0] p1_a_reg, p2_a_reg, p3_a_reg, p4_a_reg;
    logic [24:0] p1_s_reg, p2_s_reg, p3_s_reg;
    logic [21:0] p2_r1_reg;
    logic [22:0] p3_n2_reg, p4_n3_reg;
    logic [24:0] p5_r_reg;
    logic [26:0] p6_ang_reg;
    logic [44:0] p7_pm_reg;
    logic [42:0] p7_ps_reg, p8_ps_reg;
    logic [16:0] p8_d0_reg;
    logic [43:0] p8_dt_reg;
    side_t       p1_side_reg, p2_side_reg, p3_side_reg, p4_side_reg;
    side_t       p5_side_reg, p6_side_reg, p7_side_reg, p8_side_reg;

    // amplitude joins the flags once the root is complete
    side_t       p1_side_c;

    always_comb
    begin
        p1_side_c     = side_reg[LOOP_STAGES];
        p1_side_c.amp = sq_root_reg[LOOP_STAGES][15:1];
    end

    logic [49:0] aa_c;
    logic [44:0] sc3_c;
    logic [46:0] r1s_c;
    logic [47:0] n2s_c, n3a_c;

    assign aa_c  = 50'(div_q_reg[LOOP_STAGES]) * 50'(div_q_reg[LOOP_STAGES]);
    assign sc3_c = 45'(p1_s_reg) * 45'(COEF_C3_MAG);
    assign r1s_c = 47'(p2_r1_reg) * 47'(p2_s_reg);
    assign n2s_c = 48'(p3_n2_reg) * 48'(p3_s_reg);
    assign n3a_c = 48'(p4_n3_reg) * 48'(p4_a_reg);

    // Octant unfolding and wrap into 0..TAU
    logic signed [27:0] o1_c, o2_c, o3_c, o4_c;

    assign o1_c = p5_side_reg.swp  ? Q24_HALFPI - $signed({3'b000, p5_r_reg})
                                   : $signed({3'b000, p5_r_reg});
    assign o2_c = p5_side_reg.xneg ? Q24_PI - o1_c : o1_c;
    assign o3_c = p5_side_reg.yneg ? -o2_c : o2_c;
    assign o4_c = o3_c[27] ? o3_c + Q24_TAU_S : o3_c;

    // Depth scaling: reciprocal estimate, then one correction step
    logic [17:0] recip_c;
    logic [15:0] scale_c;
    logic [16:0] d0_c;
    logic [43:0] rem_c;
    logic [16:0] d_c;
    logic [15:0] depth_c;

    assign recip_c = narrow_reg ? RECIP_NARROW : RECIP_WIDE;
    assign scale_c = narrow_reg ? SCALE_NARROW : SCALE_WIDE;
    assign d0_c    = p7_pm_reg[44:RECIP_SHIFT];
    assign rem_c   = {1'b0, p8_ps_reg} - p8_dt_reg;
    assign d_c     = (rem_c >= 44'(Q24_TAU)) ? p8_d0_reg + 17'd1 : p8_d0_reg;
    assign depth_c = (d_c > {1'b0, scale_c}) ? scale_c : d_c[15:0];

    logic [15:0] depth_reg, amp_reg;
    logic        masked_reg;

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_xneg_reg <= x_c[11];
            s1_yneg_reg <= y_c[11];
            s1_swp_reg  <= (ay_c > ax_c);
            s1_hi_reg   <= (ax_c > ay_c) ? ax_c : ay_c;
            s1_lo_reg   <= (ax_c > ay_c) ? ay_c : ax_c;
            s1_sqx_reg  <= 22'(ax_c) * 22'(ax_c);
            s1_sqy_reg  <= 22'(ay_c) * 22'(ay_c);

            // stage 2
            tsq_reg        <= 32'(thr_reg) * 32'(thr_reg);
            l2_reg         <= l2_c;
            div_rem_reg[0] <= q0_c ? 11'(s1_lo_reg - s1_hi_reg) : s1_lo_reg;
            div_q_reg[0]   <= {24'd0, q0_c};
            div_hi_reg[0]  <= s1_hi_reg;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_v_reg[0]    <= {1'b0, l2_c};
            side_reg[0]    <= '{keep: 1'b0, xneg: s1_xneg_reg, yneg: s1_yneg_reg,
                                swp: s1_swp_reg, amp: 15'd0};

            // loop stages
            for (int k = 0; k < LOOP_STAGES; k++)
            begin
                div_rem_reg[k+1] <= div_rem_next[k];
                div_q_reg[k+1]   <= div_q_next[k];
                div_hi_reg[k+1]  <= div_hi_reg[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_v_reg[k+1]    <= sq_v_next[k];
                side_reg[k+1]    <= (k == 0) ? side1_c : side_reg[k];
            end

            // polynomial
            p1_a_reg    <= div_q_reg[LOOP_STAGES];
            p1_s_reg    <= aa_c[48:FRAC_BITS];
            p1_side_reg <= p1_side_c;

            p2_a_reg    <= p1_a_reg;
            p2_s_reg    <= p1_s_reg;
            p2_r1_reg   <= COEF_C2 - 22'(sc3_c[44:FRAC_BITS]);
            p2_side_reg <= p1_side_reg;

            p3_a_reg    <= p2_a_reg;
            p3_s_reg    <= p2_s_reg;
            p3_n2_reg   <= COEF_C1 - 23'(r1s_c[46:FRAC_BITS]);
            p3_side_reg <= p2_side_reg;

            p4_a_reg    <= p3_a_reg;
            p4_n3_reg   <= n2s_c[46:FRAC_BITS];
            p4_side_reg <= p3_side_reg;

            p5_r_reg    <= p4_a_reg - 25'(n3a_c[47:FRAC_BITS]);
            p5_side_reg <= p4_side_reg;

            p6_ang_reg  <= o4_c[26:0];
            p6_side_reg <= p5_side_reg;

            // depth scaling
            p7_pm_reg   <= 45'(p6_ang_reg) * 45'(recip_c);
            p7_ps_reg   <= 43'(p6_ang_reg) * 43'(scale_c);
            p7_side_reg <= p6_side_reg;

            p8_d0_reg   <= d0_c;
            p8_dt_reg   <= 44'(d0_c) * 44'(Q24_TAU);
            p8_ps_reg   <= p7_ps_reg;
            p8_side_reg <= p7_side_reg;

            // output register
            depth_reg  <= p8_side_reg.keep ? depth_c : 16'd0;
            amp_reg    <= {1'b0, p8_side_reg.amp};
            masked_reg <= !p8_side_reg.keep;
        end
    end

    assign depth_valid = vld_reg[DEPTH-1];
    assign depth_code  = depth_reg;
    assign amplitude   = amp_reg;
    assign masked      = masked_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && masked |-> depth_code == 16'd0)
        else $error("masked pixel with nonzero depth");

    a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && narrow_reg |-> depth_code <= SCALE_NARROW)
        else $error("depth above 12-bit scale");

    a_zero_amp_masked: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && amplitude == 16'd0 |-> masked)
        else $error("zero amplitude pixel not masked");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while held");

endmodule

/* tb/four_phase_tof_depth_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_phase_tof_depth_test
// Self-checking bench for the ToF depth pipeline: a directed pixel table, then
// random pixels under several flow-control phases and register settings, each
// result compared against an in-bench fixed-point model of the demodulation.
// ----------------------------------------------------------------------------
module four_phase_tof_depth_test;
    import tofd_pkg::*;

    typedef struct {
        logic [15:0] depth_code;
        logic [15:0] amplitude;
        logic        masked;
    } pixel_out_t;

    // Directed pixel: samples plus an optional typed-in result
    typedef struct {
        logic [11:0] a, b, c, d;
        logic        known;
        logic [15:0] depth_code;
        logic [15:0] amplitude;
        logic        masked;
    } pixel_row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int Q24_ONE_I      = 16777216;
    localparam int NUM_ROWS       = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        sample_valid;
    logic        sample_stall;
    logic [11:0] sample_a, sample_b, sample_c, sample_d;
    logic        depth_valid;
    logic        depth_stall;
    logic [15:0] depth_code;
    logic [15:0] amplitude;
    logic        masked;

    four_phase_tof_depth dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .sample_c     (sample_c),
        .sample_d     (sample_d),
        .depth_valid  (depth_valid),
        .depth_stall  (depth_stall),
        .depth_code   (depth_code),
        .amplitude    (amplitude),
        .masked       (masked)
    );

    // Local copy of the two registers
    logic [15:0] thr_reg;
    logic        narrow_reg;

    pixel_out_t pending_pixels[$];
    int mismatches;
    int results_seen;
    int masked_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Low 11 bits as signed, times 16
    function automatic longint phase_value(logic [11:0] raw);
        longint v;
        v = raw[9:0];
        if (raw[10])
            v = v - 1024;
        return v * 16;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q24 multiply, truncating toward zero
    function automatic longint q24_mul(longint p, longint q);
        return (p * q) / Q24_ONE_I;
    endfunction

    function automatic longint phase_angle(longint x, longint y);
        longint ax, ay, hi, lo, a, s, r;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        hi = ax > ay ? ax : ay;
        lo = ax > ay ? ay : ax;
        if (hi == 0)
            return 0;
        a = (lo << 24) / hi;
        s = q24_mul(a, a);
        r = q24_mul(s, -longint'(COEF_C3_MAG)) + longint'(COEF_C2);
        r = q24_mul(r, s) - longint'(COEF_C1);
        r = q24_mul(r, s);
        r = q24_mul(r, a) + a;
        if (ay > ax)
            r = longint'(Q24_HALFPI) - r;
        if (x < 0)
            r = longint'(Q24_PI) - r;
        if (y < 0)
            r = -r;
        if (r < 0)
            r = r + longint'(Q24_TAU);
        return r;
    endfunction

    function automatic pixel_out_t demodulate(logic [11:0] a, logic [11:0] b,
                                              logic [11:0] c, logic [11:0] d);
        pixel_out_t o;
        longint x, y, r, scale, dv;
        longint unsigned l2, lim;
        y = phase_value(c) - phase_value(a);
        x = phase_value(d) - phase_value(b);
        l2 = x * x + y * y;
        lim = 4 * longint'(thr_reg) * longint'(thr_reg);
        o.amplitude = 16'(isqrt(l2) >> 1);
        o.depth_code = '0;
        o.masked = 1'b1;
        if (l2 > lim)
        begin
            r = phase_angle(x, y);
            scale = narrow_reg ? 4095 : 65535;
            dv = (r * scale) / longint'(Q24_TAU);
            if (dv > scale)
                dv = scale;
            if (dv < 0)
                dv = 0;
            o.depth_code = 16'(dv);
            o.masked = 1'b0;
        end
        return o;
    endfunction

    // Result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (depth_valid && !depth_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (depth_valid && !depth_stall)
            begin
                results_seen <= results_seen + 1;
                if (masked)
                    masked_seen <= masked_seen + 1;
                if (pending_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result depth=%0d amp=%0d m=%0b",
                                 depth_code, amplitude, masked);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    pixel_out_t e;
                    e = pending_pixels.pop_front();
                    if (e.depth_code !== depth_code || e.amplitude !== amplitude
                        || e.masked !== masked)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: exp depth=%0d amp=%0d m=%0b, got %0d %0d %0b",
                                     e.depth_code, e.amplitude, e.masked,
                                     depth_code, amplitude, masked);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // Receiver stalls at the rate of the current phase
    always @(posedge clk)
    begin
        if (rst_n)
            depth_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("four_phase_tof_depth_test: errors");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_reg = val;
        else
            narrow_reg = val[0];
    endtask

    // One pixel transfer; the expectation is queued when it is accepted
    task automatic send_pixel(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                              logic [11:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_a <= a;
        sample_b <= b;
        sample_c <= c;
        sample_d <= d;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_pixels.push_back(demodulate(a, b, c, d));
    endtask

    task automatic drain_pipe();
        sample_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random sample: full range, sometimes clustered so the vector is small
    function automatic logic [11:0] rand_sample(logic [11:0] base, int spread);
        if (spread == 0)
            return 12'($urandom_range(4095));
        return {1'($urandom_range(1)), 11'(base[10:0] + $urandom_range(spread))};
    endfunction

    task automatic random_burst(int count);
        logic [11:0] base;
        int spread;
        for (int i = 0; i < count; i++)
        begin
            base = 12'($urandom_range(4095));
            spread = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
            send_pixel(rand_sample(base, spread), rand_sample(base, spread),
                       rand_sample(base, spread), rand_sample(base, spread));
        end
    endtask

    pixel_row_t pixel_rows[NUM_ROWS];

    initial
    begin
        pixel_out_t e;
        int phase_pct[4][2];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = '0;
        sample_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        sample_c = '0;
        sample_d = '0;
        depth_stall = 1'b0;
        thr_reg = '0;
        narrow_reg = 1'b0;
        mismatches = 0;
        results_seen = 0;
        masked_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        timed_out = 1'b0;
        phase_pct = '{'{0, 0}, '{84, 0}, '{0, 84}, '{16, 16}};

        // Directed rows; known results are the trivial ones
        pixel_rows = '{
            // zero vector: always masked, even with threshold 0
            '{12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 16'd0, 16'd0, 1'b1},
            // upper bit ignored: same as zero vector
            '{12'h800, 12'h800, 12'h000, 12'h000, 1'b1, 16'd0, 16'd0, 1'b1},
            '{12'hFFF, 12'h7FF, 12'hFFF, 12'h7FF, 1'b1, 16'd0, 16'd0, 1'b1},
            // pure +x axis: angle 0
            '{12'h000, 12'h000, 12'h000, 12'h001, 1'b1, 16'd0, 16'd8, 1'b0},
            // max extent on each axis, both signs
            '{12'h400, 12'h400, 12'h3FF, 12'h3FF, 1'b0, 0, 0, 0},
            '{12'h3FF, 12'h3FF, 12'h400, 12'h400, 1'b0, 0, 0, 0},
            '{12'h3FF, 12'h000, 12'h400, 12'h000, 1'b0, 0, 0, 0},
            '{12'h000, 12'h3FF, 12'h000, 12'h400, 1'b0, 0, 0, 0},
            '{12'h400, 12'h000, 12'h3FF, 12'h000, 1'b0, 0, 0, 0},
            '{12'h000, 12'h400, 12'h000, 12'h3FF, 1'b0, 0, 0, 0},
            // diagonals and near-wrap angles
            '{12'h000, 12'h000, 12'h7FF, 12'h001, 1'b0, 0, 0, 0},
            '{12'h000, 12'h000, 12'h001, 12'h001, 1'b0, 0, 0, 0},
            '{12'h001, 12'h001, 12'h000, 12'h000, 1'b0, 0, 0, 0},
            '{12'h000, 12'h000, 12'h001, 12'h7FF, 1'b0, 0, 0, 0},
            '{12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0, 0, 0, 0},
            '{12'h123, 12'h456, 12'h789, 12'hABC, 1'b0, 0, 0, 0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: threshold 0, wide scale
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (pixel_rows[i].known)
            begin
                e = demodulate(pixel_rows[i].a, pixel_rows[i].b,
                               pixel_rows[i].c, pixel_rows[i].d);
                if (e.depth_code !== pixel_rows[i].depth_code
                    || e.amplitude !== pixel_rows[i].amplitude
                    || e.masked !== pixel_rows[i].masked)
                begin
                    $display("table row %0d disagrees with model", i);
                    mismatches++;
                end
            end
            send_pixel(pixel_rows[i].a, pixel_rows[i].b, pixel_rows[i].c,
                       pixel_rows[i].d);
        end
        drain_pipe();

        // Directed again under narrow scale, then one pixel with the threshold at its maximum
        write_reg(CFG_NARROW, 16'd1);
        for (int i = 0; i < NUM_ROWS; i++)
            send_pixel(pixel_rows[i].a, pixel_rows[i].b, pixel_rows[i].c,
                       pixel_rows[i].d);
        drain_pipe();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        send_pixel(12'h400, 12'h400, 12'h3FF, 12'h3FF);
        drain_pipe();

        // Random phases: each flow-control mix under several register settings
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int k = 0; k < 4; k++)
            begin
                drain_pipe();
                case (k)
                    0: write_reg(CFG_THRESHOLD, 16'd0);
                    1: write_reg(CFG_THRESHOLD, 16'($urandom_range(2000)));
                    2: write_reg(CFG_THRESHOLD, 16'($urandom_range(200)));
                    default: write_reg(CFG_THRESHOLD, 16'($urandom_range(65535)));
                endcase
                write_reg(CFG_NARROW, 16'($urandom_range(1)));
                random_burst(70);
                // a stretch with no sender idles inside each phase
                send_idle_pct = 0;
                random_burst(20);
                send_idle_pct = phase_pct[p][0];
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_pipe();

        $display("covered %0d results (%0d masked) over four flow-control phases",
                 results_seen, masked_seen);
        $display("with threshold and scale changed between bursts");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("four_phase_tof_depth_test: clean");
        else
            $display("four_phase_tof_depth_test: errors");
        $finish;
    end

endmodule
